/* hdl/usis_pkg.sv */
package usis_pkg;

  localparam int T_MAX_DEF = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int WAYS_W    = 64;
  localparam int RAND_W    = 31;
  localparam int PT_W      = 5;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = HALF_W + RAND_W;
  localparam int WIDE_W    = WAYS_W + RAND_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] NUM_POINTS_RST = CFG_W'(8);
  localparam logic [CFG_W-1:0] MAX_LEN_RST    = CFG_W'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RB_INIT,
    ST_RB_RD,
    ST_RB_WAIT,
    ST_RB_WR,
    ST_SUM_RD,
    ST_SUM_LD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_X_ADD,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rb_init;
    logic rb_rd;
    logic rb_wr;
    logic sum_rd;
    logic sum_ld;
    logic mul_lo;
    logic mul_hi;
    logic x_add;
    logic scan;
    logic take_hit;
    logic take_max;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic rb_j_last;
    logic rb_k_last;
    logic m_zero;
    logic hit;
    logic scan_last;
  } stat_t;

endpackage

/* hdl/usis_ram.sv */
module usis_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/usis_dp.sv */
module usis_dp #(
  parameter int T_MAX = usis_pkg::T_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr,
  input  logic [usis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usis_pkg::CFG_W-1:0]     cfg_data,
  input  logic [usis_pkg::RAND_W-1:0]    in_rand_value,
  input  usis_pkg::cmd_t                 cmd,
  output usis_pkg::stat_t                stat,
  output logic                           out_covered,
  output logic [usis_pkg::PT_W-1:0]      out_start_point,
  output logic [usis_pkg::PT_W-1:0]      out_end_point,
  output logic                           out_set_done
);

  import usis_pkg::*;

  localparam int PW = $clog2(T_MAX + 1);
  localparam logic [PW-1:0] ONE = PW'(1);

  logic [CFG_W-1:0]  num_points_r, max_len_r;
  logic [PW-1:0]     pos_r, k_r, j_r, li_r, l1_r, l2_r, l3_r, sel_r;
  logic              v1_r, v2_r, v3_r, rd_v_r;
  logic [RAND_W-1:0] r_r;
  logic [WAYS_W-1:0] acc_r, sum_r, cum_r;
  logic [PROD_W-1:0] plo_r, phi_r;
  logic [WIDE_W-1:0] x_r, y_r;
  logic              covered_r, done_r;
  logic [PT_W-1:0]   start_r, end_r;

  logic [PW-1:0]     n, rem, m, ml;
  logic              issue;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic [WAYS_W-1:0] ram_wdata, rdata;
  logic [HALF_W-1:0] mul_a;
  logic [PROD_W-1:0] prod;
  logic [WIDE_W-1:0] y_nxt;
  logic [PW:0]       adv, last_pt;

  // effective point count saturates at T_MAX
  assign n   = (num_points_r > CFG_W'(T_MAX)) ? PW'(T_MAX) : PW'(num_points_r);
  assign rem = n - pos_r;
  assign m   = (CFG_W'(rem) < max_len_r) ? rem : PW'(max_len_r);
  assign ml  = (CFG_W'(k_r) < max_len_r) ? k_r : PW'(max_len_r);

  assign issue = cmd.scan && (li_r != m);

  always_comb begin
    ram_we    = cmd.rb_init || cmd.rb_wr;
    ram_waddr = cmd.rb_init ? '0 : k_r;
    ram_wdata = cmd.rb_init ? WAYS_W'(1) : acc_r;
    if (cmd.rb_rd) begin
      ram_raddr = (j_r == '0) ? (k_r - ONE) : (k_r - j_r);
    end else if (cmd.sum_rd) begin
      ram_raddr = rem;   // ways[rem] equals the total weight
    end else begin
      ram_raddr = (li_r == '0) ? (rem - ONE) : (rem - li_r);
    end
  end

  usis_ram #(
    .W     (WAYS_W),
    .DEPTH (T_MAX + 1)
  ) u_ways (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // one 32x31 multiplier, used for both halves of sum
  assign mul_a = cmd.mul_hi ? sum_r[WAYS_W-1:HALF_W] : sum_r[HALF_W-1:0];
  assign prod  = PROD_W'(mul_a) * PROD_W'(r_r);

  // cum * (2^31 - 1)
  assign y_nxt = {cum_r, {RAND_W{1'b0}}} - WIDE_W'(cum_r);

  assign adv     = {1'b0, pos_r} + ((sel_r != '0) ? {1'b0, sel_r} : (PW + 1)'(1));
  assign last_pt = {1'b0, pos_r} + {1'b0, sel_r} - (PW + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RST;
      max_len_r    <= MAX_LEN_RST;
      pos_r        <= '0;
      rd_v_r       <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
    end else begin
      rd_v_r <= cmd.rb_rd;
      v1_r   <= issue;
      v2_r   <= v1_r && !cmd.x_add;
      v3_r   <= v2_r && !cmd.x_add;
      if (cfg_wr) begin
        case (cfg_index)
          REG_NUM_POINTS: num_points_r <= cfg_data;
          REG_MAX_LEN:    max_len_r    <= cfg_data;
          default:        ;
        endcase
        pos_r <= '0;
      end else if (cmd.load_in && (pos_r >= n)) begin
        pos_r <= '0;
      end else if (cmd.out_load) begin
        pos_r <= (adv >= {1'b0, n}) ? '0 : adv[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_r <= in_rand_value;
    end
    // table rebuild
    if (rd_v_r) begin
      acc_r <= acc_r + rdata;
    end
    if (cmd.rb_rd) begin
      j_r <= j_r + ONE;
    end
    if (cmd.rb_init) begin
      k_r   <= ONE;
      j_r   <= '0;
      acc_r <= '0;
    end else if (cmd.rb_wr) begin
      k_r   <= k_r + ONE;
      j_r   <= '0;
      acc_r <= '0;
    end
    // draw
    if (cmd.sum_ld) begin
      sum_r <= rdata;
    end
    if (cmd.mul_lo) begin
      plo_r <= prod;
    end
    if (cmd.mul_hi) begin
      phi_r <= prod;
    end
    if (cmd.x_add) begin
      x_r  <= {phi_r, {HALF_W{1'b0}}} + WIDE_W'(plo_r);
      li_r <= '0;
      cum_r <= '0;
    end else begin
      if (issue) begin
        li_r <= li_r + ONE;
      end
      if (v1_r) begin
        cum_r <= cum_r + rdata;
      end
    end
    l1_r <= li_r;
    l2_r <= l1_r;
    l3_r <= l2_r;
    y_r  <= y_nxt;
    if (cmd.take_hit) begin
      sel_r <= l3_r;
    end else if (cmd.take_max) begin
      sel_r <= m;
    end
    if (cmd.out_load) begin
      covered_r <= (sel_r != '0);
      start_r   <= PT_W'(pos_r);
      end_r     <= (sel_r != '0) ? PT_W'(last_pt) : PT_W'(pos_r);
      done_r    <= (adv >= {1'b0, n});
    end
  end

  always_comb begin
    stat.n_zero    = (n == '0);
    stat.rb_j_last = (j_r == ml);
    stat.rb_k_last = (k_r == n);
    stat.m_zero    = (m == '0);
    stat.hit       = v3_r && (x_r <= y_r);
    stat.scan_last = v3_r && (l3_r == (m - ONE));
  end

  assign out_covered     = covered_r;
  assign out_start_point = start_r;
  assign out_end_point   = end_r;
  assign out_set_done    = done_r;

endmodule

/* hdl/usis_ctrl.sv */
module usis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  usis_pkg::stat_t stat,
  output usis_pkg::cmd_t  cmd
);

  import usis_pkg::*;

  state_t state_r, state_nxt;
  logic   tbl_ready_r, tbl_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tbl_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tbl_ready_r <= tbl_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tbl_ready_nxt = tbl_ready_r;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (stat.n_zero) begin
            state_nxt = ST_IDLE;          // no set exists, word dropped
          end else if (!tbl_ready_r) begin
            state_nxt = ST_RB_INIT;
          end else begin
            state_nxt = ST_SUM_RD;
          end
        end
      end
      ST_RB_INIT: begin
        cmd.rb_init = 1'b1;
        state_nxt   = ST_RB_RD;
      end
      ST_RB_RD: begin
        cmd.rb_rd = 1'b1;
        if (stat.rb_j_last) begin
          state_nxt = ST_RB_WAIT;
        end
      end
      ST_RB_WAIT: begin
        state_nxt = ST_RB_WR;
      end
      ST_RB_WR: begin
        cmd.rb_wr = 1'b1;
        if (stat.rb_k_last) begin
          tbl_ready_nxt = 1'b1;
          state_nxt     = ST_SUM_RD;
        end else begin
          state_nxt = ST_RB_RD;
        end
      end
      ST_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = ST_SUM_LD;
      end
      ST_SUM_LD: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_X_ADD;
      end
      ST_X_ADD: begin
        cmd.x_add = 1'b1;
        if (stat.m_zero) begin
          cmd.take_max = 1'b1;
          state_nxt    = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_FIN;
        end else if (stat.scan_last) begin
          cmd.take_max = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_wr) begin
      tbl_ready_nxt = 1'b0;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/uniform_interval_set_sampler.sv */
// Uniform interval set sampler.
// Input channel (in_valid / in_stall / in_rand_value): one random word per
// step, full scale 2^31-1. Each accepted word yields one result word on the
// output channel (out_valid / out_stall / out_covered, out_start_point,
// out_end_point, out_set_done); out_set_done marks the last word of a set.
// If the effective point count is zero a word is taken and dropped.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// num_points, index 1 is max_len; other indexes are ignored. cfg_ready is
// always high; the user must write only while the block is idle; the
// block itself does not enforce this. A write restarts the set at point 0
// and forces a table rebuild. Timing: the scan reads one table entry per
// cycle through the single read port of the ways table. One word is in
// flight at a time.
// The first word after reset or a config write also rebuilds the table
// for k = 1..n.
// Reset (rst_n, synchronous) loads num_points = 8 and max_len = 4, clears
// the position, drops any pending result and marks the table stale.
// A stalled result sits in the output register; the next input word is
// still accepted and is held back only at its own result stage.
module uniform_interval_set_sampler #(
  parameter int T_MAX = usis_pkg::T_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [usis_pkg::RAND_W-1:0]    in_rand_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_covered,
  output logic [usis_pkg::PT_W-1:0]      out_start_point,
  output logic [usis_pkg::PT_W-1:0]      out_end_point,
  output logic                           out_set_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [usis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usis_pkg::CFG_W-1:0]     cfg_data
);

  import usis_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  assign cfg_ready = 1'b1;

  // only known register indexes restart the set / rebuild the table
  assign cfg_wr = cfg_valid && cfg_ready &&
                  ((cfg_index == REG_NUM_POINTS) || (cfg_index == REG_MAX_LEN));

  usis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  usis_dp #(
    .T_MAX (T_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr          (cfg_wr),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_rand_value   (in_rand_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_covered     (out_covered),
    .out_start_point (out_start_point),
    .out_end_point   (out_end_point),
    .out_set_done    (out_set_done)
  );

`ifndef SYNTHESIS
  // a new result never overwrites a word the receiver is still stalling
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled output word");

  // table write waits out ST_RB_WAIT after the last read so the sum is complete
  a_rb_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rb_wr |-> ($past(cmd.rb_rd, 2) && !$past(cmd.rb_rd)))
    else $error("table entry written before its sum settled");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import usis_pkg::*;

  localparam int T_MAX          = T_MAX_DEF;
  localparam int RAND_ITEMS     = 800;   // random draws in phases with points
  localparam int PHASE_WORDS    = 40;
  localparam int SETTLE_CYCLES  = T_MAX + 32;  // covers one scan plus margin
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [RAND_W-1:0]    RAND_FULL    = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  // One result word of the sampler.
  typedef struct packed {
    logic            covered;
    logic [PT_W-1:0] start_pt;
    logic [PT_W-1:0] end_pt;
    logic            set_done;
  } span_t;

  localparam span_t NO_SPAN = '0;

  typedef enum logic {ROW_CFG, ROW_DRAW} row_kind_t;

  // Directed stimulus row: a register write or one draw. When typed is set,
  // want is the result typed in by hand; otherwise the predictor
  // supplies it.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [RAND_W-1:0]     r;
    logic                  typed;
    span_t                 want;
  } plan_row_t;

  localparam int DIR_ROWS = 27;

  plan_row_t plan [DIR_ROWS] = '{
    // reset config: 8 points, max_len 4
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd0,          1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd1, 5'd4, 1'b0}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd5, 5'd7, 1'b1}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'h4000_0000,  1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd1,          1'b0, NO_SPAN},
    // max_len 0: no interval allowed, even at full scale
    '{ROW_CFG,  REG_MAX_LEN,    6'd0,  31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'h5555_5555,  1'b0, NO_SPAN},
    // single point, max_len above num_points
    '{ROW_CFG,  REG_NUM_POINTS, 6'd1,  31'd0,          1'b0, NO_SPAN},
    '{ROW_CFG,  REG_MAX_LEN,    6'd32, 31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd0,          1'b1, '{1'b0, 5'd0, 5'd0, 1'b1}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd0, 5'd0, 1'b1}},
    // zero points: words are swallowed
    '{ROW_CFG,  REG_NUM_POINTS, 6'd0,  31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd0,          1'b0, NO_SPAN},
    // 63 saturates to T_MAX
    '{ROW_CFG,  REG_NUM_POINTS, 6'd63, 31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd0, 5'd31, 1'b1}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd0,          1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}},
    // unknown index must not restart the set
    '{ROW_CFG,  REG_UNUSED_2,   6'd63, 31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd1, 5'd31, 1'b1}},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'd0,          1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}},
    // write mid-set restarts at point 0
    '{ROW_CFG,  REG_MAX_LEN,    6'd32, 31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  RAND_FULL,      1'b1, '{1'b1, 5'd0, 5'd31, 1'b1}},
    '{ROW_CFG,  REG_UNUSED_3,   6'd0,  31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'h2AAA_AAAA,  1'b0, NO_SPAN},
    '{ROW_CFG,  REG_MAX_LEN,    6'd63, 31'd0,          1'b0, NO_SPAN},
    '{ROW_DRAW, REG_NUM_POINTS, 6'd0,  31'h7FFF_FFFE,  1'b0, NO_SPAN}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RAND_W-1:0]    in_rand_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_covered;
  logic [PT_W-1:0]      out_start_point;
  logic [PT_W-1:0]      out_end_point;
  logic                 out_set_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Shadow of the sampler: config, counting table, set position.
  logic [CFG_W-1:0]  pts_cfg = NUM_POINTS_RST;
  logic [CFG_W-1:0]  len_cfg = MAX_LEN_RST;
  logic [WAYS_W-1:0] ways_tab [0:T_MAX];
  int unsigned       pos = 0;
  bit                ways_ok = 1'b0;

  span_t span_q [$];     // results still owed by the DUT, oldest first
  int    errors = 0;
  int    snd_pct = 0;    // sender idle odds, percent per cycle
  int    rcv_pct = 0;    // receiver stall odds, percent per cycle
  int    hold_asked = 0; // bumped by the sequence to start a long hold-off
  int    hold_seen = 0;
  int    hold_left = 0;
  int    quiet = 0;      // cycles without any handshake

  always #4 clk = ~clk;

  uniform_interval_set_sampler DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rand_value   (in_rand_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_covered     (out_covered),
    .out_start_point (out_start_point),
    .out_end_point   (out_end_point),
    .out_set_done    (out_set_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Predict the span for one draw and advance the shadow position.
  // Returns 0 when the point count is zero and the word yields nothing.
  function automatic bit draw_span(input logic [RAND_W-1:0] r, output span_t s);
    int unsigned n, rem, m, sel, ml;
    logic [WAYS_W-1:0] acc, total, run;
    logic [95:0] lhs, rhs;
    s = NO_SPAN;
    n = (pts_cfg > T_MAX) ? T_MAX : pts_cfg;
    if (n == 0)
      return 1'b0;
    // Table rebuild on the first draw after reset or a write.
    if (!ways_ok) begin
      ways_tab[0] = 1;
      for (int k = 1; k <= n; k++) begin
        acc = ways_tab[k-1];
        ml = (len_cfg < k) ? len_cfg : k;
        for (int l = 1; l <= ml; l++)
          acc += ways_tab[k-l];
        ways_tab[k] = acc;
      end
      ways_ok = 1'b1;
    end
    if (pos >= n)
      pos = 0;
    rem = n - pos;
    m = (len_cfg < rem) ? len_cfg : rem;
    // length 0 and length 1 both weigh ways[rem-1]
    total = ways_tab[rem-1];
    for (int l = 1; l <= m; l++)
      total += ways_tab[rem-l];
    sel = m;
    run = 0;
    for (int l = 0; l < m; l++) begin
      run += (l == 0) ? ways_tab[rem-1] : ways_tab[rem-l];
      // exact form of r/FULL <= cum/total
      lhs = 96'(total) * 96'(r);
      rhs = 96'(run) * 96'(RAND_FULL);
      if (lhs <= rhs) begin
        sel = l;
        break;
      end
    end
    s.covered  = (sel != 0);
    s.start_pt = PT_W'(pos);
    if (sel != 0) begin
      s.end_pt = PT_W'(pos + sel - 1);
      pos += sel;
    end else begin
      s.end_pt = PT_W'(pos);
      pos += 1;
    end
    if (pos >= n) begin
      s.set_done = 1'b1;
      pos = 0;
    end
    return 1'b1;
  endfunction

  // Offer one draw; idle gaps go before it. Valid is left high so the next
  // word can follow back to back.
  task automatic send_word(input logic [RAND_W-1:0] r, input logic typed,
                           input span_t want);
    span_t s;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rand_value <= r;
    do @(posedge clk); while (in_stall);
    if (draw_span(r, s))
      span_q = {span_q, (typed ? want : s)};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_NUM_POINTS: begin
        pts_cfg = data;
        ways_ok = 1'b0;
        pos     = 0;
      end
      REG_MAX_LEN: begin
        len_cfg = data;
        ways_ok = 1'b0;
        pos     = 0;
      end
      default: ;  // unknown index: no effect
    endcase
  endtask

  // Drop valid, wait out every owed result, then let a swallowed word
  // (zero points) finish too.
  task automatic settle();
    in_valid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: checks each accepted word, then picks next cycle's stall.
  // A hold-off request pins stall high until hold_left counts down from HOLD_CYCLES.
  always @(posedge clk) begin
    span_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_covered, out_start_point, out_end_point, out_set_done};
      if (span_q.size() == 0) begin
        $display("%0t: unexpected word cov=%0d start=%0d end=%0d done=%0d", $time,
                 got.covered, got.start_pt, got.end_pt, got.set_done);
        errors++;
      end else begin
        want = span_q.pop_front();
        if (got.covered !== want.covered) begin
          $display("%0t: covered expected %0d got %0d", $time, want.covered, got.covered);
          errors++;
        end
        if (got.start_pt !== want.start_pt) begin
          $display("%0t: start_point expected %0d got %0d", $time, want.start_pt,
                   got.start_pt);
          errors++;
        end
        if (got.end_pt !== want.end_pt) begin
          $display("%0t: end_point expected %0d got %0d", $time, want.end_pt, got.end_pt);
          errors++;
        end
        if (got.set_done !== want.set_done) begin
          $display("%0t: set_done expected %0d got %0d", $time, want.set_done,
                   got.set_done);
          errors++;
        end
      end
    end
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  // Watchdog: any handshake clears the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    int ph;
    int nwords;
    logic [RAND_W-1:0] r;
    logic [CFG_W-1:0]  new_pts, new_len;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].r, plan[i].typed, plan[i].want);
      end
    end

    // Backpressure: receiver holds off while the sender keeps offering,
    // so the output register fills and in_stall must rise.
    settle();
    write_reg(REG_NUM_POINTS, 6'd12);
    write_reg(REG_MAX_LEN, 6'd4);
    hold_asked <= hold_asked + 1;
    repeat (30) send_word(31'($urandom()), 1'b0, NO_SPAN);

    // Random phases; idle pattern rotates, config changes between phases.
    counted = 0;
    ph = 0;
    while (counted < RAND_ITEMS) begin
      settle();
      case ($urandom_range(9))
        0:       new_pts = '0;
        1:       new_pts = CFG_W'($urandom_range(32, 63));
        default: new_pts = CFG_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(9))
        0:       new_len = CFG_W'($urandom_range(33, 63));
        1:       new_len = '0;
        default: new_len = CFG_W'($urandom_range(1, 8));
      endcase
      if ($urandom_range(1)) begin
        write_reg(REG_NUM_POINTS, new_pts);
        write_reg(REG_MAX_LEN, new_len);
      end else begin
        write_reg(REG_MAX_LEN, new_len);
        write_reg(REG_NUM_POINTS, new_pts);
      end
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_W'($urandom()));
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct <= 0;  end
        1: begin snd_pct = 76; rcv_pct <= 0;  end
        2: begin snd_pct = 0;  rcv_pct <= 76; end
        default: begin snd_pct = 31; rcv_pct <= 31; end
      endcase
      nwords = (pts_cfg == 0) ? 6 : PHASE_WORDS;
      repeat (nwords) begin
        case ($urandom_range(7))
          0:       r = '0;
          1:       r = RAND_FULL;
          default: r = RAND_W'($urandom());
        endcase
        send_word(r, 1'b0, NO_SPAN);
      end
      if (pts_cfg != 0)
        counted += nwords;
      ph++;
    end

    settle();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
